### sv/sha512_pkg.sv
// Package for the SHA-512 hash unit: round constants, initial hash values,
// the command word passed from front to back, and the round helper functions.
// No dependencies.
package sha512_pkg;

    localparam int WORD_W = 64;
    localparam int CMD_DEPTH_DEFAULT = 4;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        CMD_DATA = 2'd0,
        CMD_PAD  = 2'd1,
        CMD_LEN  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        word_t     data;
    } cmd_t;

    function automatic word_t round_k(input logic [6:0] r);
        word_t k;
        unique case (r)
            7'd0:  k = 64'h428a2f98d728ae22; 7'd1:  k = 64'h7137449123ef65cd;
            7'd2:  k = 64'hb5c0fbcfec4d3b2f; 7'd3:  k = 64'he9b5dba58189dbbc;
            7'd4:  k = 64'h3956c25bf348b538; 7'd5:  k = 64'h59f111f1b605d019;
            7'd6:  k = 64'h923f82a4af194f9b; 7'd7:  k = 64'hab1c5ed5da6d8118;
            7'd8:  k = 64'hd807aa98a3030242; 7'd9:  k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic word_t init_hash(input logic [2:0] i);
        word_t h;
        unique case (i)
            3'd0: h = 64'h6a09e667f3bcc908;
            3'd1: h = 64'hbb67ae8584caa73b;
            3'd2: h = 64'h3c6ef372fe94f82b;
            3'd3: h = 64'ha54ff53a5f1d36f1;
            3'd4: h = 64'h510e527fade682d1;
            3'd5: h = 64'h9b05688c2b3e6c1f;
            3'd6: h = 64'h1f83d9abfb41bd6b;
            default: h = 64'h5be0cd19137e2179;
        endcase
        return h;
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

endpackage

### sv/sha512_hash_unit.sv
// Top level of the SHA-512 hash unit: front end, command queue, back end.
// Uses sha512_pkg, sha512_front, sha512_cmd_fifo and sha512_back.
//
//   channel   handshake      payload
//   input     push / full    message_word, valid_bytes, is_last
//   result    pop / empty    digest_word, word_index, last_word
//
// A full 128-byte block is loaded word by word, then takes 80 rounds and one fold
// into the hash values; the single round unit loads no new block until the fold is done.
// A last word adds the padding words and a further block or two of rounds,
// then eight digest transfers. Reset loads the initial hash values at once.
// The input stalls while padding is issued or the command queue is full.
module sha512_hash_unit #(
    parameter int CMD_DEPTH = sha512_pkg::CMD_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [63:0] message_word,
    input  logic [3:0]  valid_bytes,
    input  logic        is_last,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import sha512_pkg::*;

    logic f_valid, f_ready, q_valid, q_pop;
    cmd_t f_cmd, q_cmd;

    sha512_front u_front (
        .clk, .rst_n, .push, .full, .message_word, .valid_bytes, .is_last,
        .cmd_valid(f_valid), .cmd(f_cmd), .cmd_ready(f_ready)
    );

    sha512_cmd_fifo #(.DEPTH(CMD_DEPTH)) u_fifo (
        .clk, .rst_n, .wr_en(f_valid), .wr_data(f_cmd), .wr_ready(f_ready),
        .rd_valid(q_valid), .rd_data(q_cmd), .rd_en(q_pop)
    );

    sha512_back u_back (
        .clk, .rst_n, .cmd_valid(q_valid), .cmd(q_cmd), .cmd_pop(q_pop),
        .empty, .pop, .digest_word, .word_index, .last_word
    );

endmodule

### sv/sha512_front.sv
// Front end of the SHA-512 hash unit: takes message words, keeps the byte count
// and turns each word into data, padding and length commands. Uses sha512_pkg.
module sha512_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [63:0]         message_word,
    input  logic [3:0]          valid_bytes,
    input  logic                is_last,
    output logic                cmd_valid,
    output sha512_pkg::cmd_t    cmd,
    input  logic                cmd_ready
);
    import sha512_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXTRA,
        ST_ZERO,
        ST_LEN
    } state_t;

    state_t      state_reg, state_next;
    logic [63:0] len_reg, len_next;
    logic [3:0]  pos_reg, pos_next;
    logic [3:0]  vb;
    logic [63:0] keep;

    assign vb = (valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
    assign full = (state_reg != ST_IDLE) || !cmd_ready;

    always_comb
    begin
        keep = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (4'(b) < vb)
            begin
                keep[63-8*b -: 8] = 8'hff;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        cmd_valid  = 1'b0;
        cmd.kind   = CMD_DATA;
        cmd.data   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (push && cmd_ready)
                begin
                    cmd_valid = 1'b1;
                    pos_next  = pos_reg + 4'd1;
                    if (!is_last)
                    begin
                        cmd.data = message_word;
                        len_next = len_reg + 64'd8;
                    end
                    else
                    begin
                        len_next = len_reg + 64'(vb);
                        if (vb == 4'd8)
                        begin
                            cmd.data   = message_word;
                            state_next = ST_EXTRA;
                        end
                        else
                        begin
                            cmd.data   = (message_word & keep) |
                                         (64'h80 << (7'd56 - {vb[2:0], 3'b000}));
                            state_next = ST_ZERO;
                        end
                    end
                end
            end
            ST_EXTRA:
            begin
                cmd_valid = cmd_ready;
                cmd.data  = 64'h8000_0000_0000_0000;
                if (cmd_ready)
                begin
                    pos_next   = pos_reg + 4'd1;
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO:
            begin
                cmd_valid = cmd_ready;
                if (cmd_ready)
                begin
                    pos_next = pos_reg + 4'd1;
                    if (pos_reg == 4'd14)
                    begin
                        state_next = ST_LEN;
                    end
                end
            end
            ST_LEN:
            begin
                cmd_valid = cmd_ready;
                cmd.kind  = CMD_LEN;
                cmd.data  = len_reg << 3;
                if (cmd_ready)
                begin
                    pos_next   = '0;
                    len_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            len_reg   <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

### sv/sha512_cmd_fifo.sv
// Short command queue between the front end and the compression back end.
// Uses sha512_pkg.
module sha512_cmd_fifo #(
    parameter int DEPTH = sha512_pkg::CMD_DEPTH_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  sha512_pkg::cmd_t wr_data,
    output logic             wr_ready,
    output logic             rd_valid,
    output sha512_pkg::cmd_t rd_data,
    input  logic             rd_en
);
    import sha512_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cmd_t          mem_reg [DEPTH];
    logic [AW-1:0] wptr_reg, rptr_reg;
    logic [AW:0]   cnt_reg;

    assign wr_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_ready)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (wr_en && wr_ready)
            begin
                wptr_reg <= (wptr_reg == AW'(DEPTH-1)) ? '0 : wptr_reg + 1'b1;
            end
            if (rd_en && rd_valid)
            begin
                rptr_reg <= (rptr_reg == AW'(DEPTH-1)) ? '0 : rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(wr_en && wr_ready) - (AW+1)'(rd_en && rd_valid);
        end
    end

endmodule

### sv/sha512_back.sv
// Back end of the SHA-512 hash unit: block buffer, 80-round compression and
// digest output read from the hash registers. Uses sha512_pkg.
module sha512_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  sha512_pkg::cmd_t cmd,
    output logic             cmd_pop,
    output logic             empty,
    input  logic             pop,
    output logic [63:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);
    import sha512_pkg::*;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } state_t;

    state_t      state_reg;
    word_t       hash_reg [8];
    word_t       sched_reg [16];
    word_t       a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;
    logic [3:0]  pos_reg;
    logic [6:0]  round_reg;
    logic        final_reg;
    logic [2:0]  out_idx_reg;

    word_t wr, s0, s1, t1, t2, w15, w2;

    assign w15 = sched_reg[1];
    assign w2  = sched_reg[14];
    assign s0  = rotr(w15, 1) ^ rotr(w15, 8) ^ (w15 >> 7);
    assign s1  = rotr(w2, 19) ^ rotr(w2, 61) ^ (w2 >> 6);
    assign wr  = (round_reg < 7'd16) ? sched_reg[0] : sched_reg[0] + s0 + sched_reg[9] + s1;
    assign t1  = h_reg + (rotr(e_reg, 14) ^ rotr(e_reg, 18) ^ rotr(e_reg, 41))
               + ((e_reg & f_reg) ^ (~e_reg & g_reg)) + round_k(round_reg) + wr;
    assign t2  = (rotr(a_reg, 28) ^ rotr(a_reg, 34) ^ rotr(a_reg, 39))
               + ((a_reg & b_reg) ^ (a_reg & c_reg) ^ (b_reg & c_reg));

    assign cmd_pop     = (state_reg == ST_LOAD) && cmd_valid;
    assign empty       = (state_reg != ST_OUT);
    assign digest_word = hash_reg[out_idx_reg];
    assign word_index  = out_idx_reg;
    assign last_word   = (out_idx_reg == 3'd7);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD && cmd_valid)
        begin
            sched_reg[pos_reg] <= cmd.data;
        end
        else if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                sched_reg[i] <= sched_reg[i+1];
            end
            sched_reg[15] <= wr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            pos_reg     <= '0;
            round_reg   <= '0;
            final_reg   <= 1'b0;
            out_idx_reg <= '0;
            a_reg <= '0; b_reg <= '0; c_reg <= '0; d_reg <= '0;
            e_reg <= '0; f_reg <= '0; g_reg <= '0; h_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= init_hash(3'(i));
            end
        end
        else
        begin
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (cmd_valid)
                    begin
                        pos_reg <= pos_reg + 4'd1;
                        if (pos_reg == 4'd15)
                        begin
                            final_reg <= (cmd.kind == CMD_LEN);
                            round_reg <= '0;
                            a_reg <= hash_reg[0]; b_reg <= hash_reg[1];
                            c_reg <= hash_reg[2]; d_reg <= hash_reg[3];
                            e_reg <= hash_reg[4]; f_reg <= hash_reg[5];
                            g_reg <= hash_reg[6]; h_reg <= hash_reg[7];
                            state_reg <= ST_ROUND;
                        end
                    end
                end
                ST_ROUND:
                begin
                    h_reg <= g_reg; g_reg <= f_reg; f_reg <= e_reg; e_reg <= d_reg + t1;
                    d_reg <= c_reg; c_reg <= b_reg; b_reg <= a_reg; a_reg <= t1 + t2;
                    round_reg <= round_reg + 7'd1;
                    if (round_reg == 7'd79)
                    begin
                        state_reg <= ST_FOLD;
                    end
                end
                ST_FOLD:
                begin
                    hash_reg[0] <= hash_reg[0] + a_reg; hash_reg[1] <= hash_reg[1] + b_reg;
                    hash_reg[2] <= hash_reg[2] + c_reg; hash_reg[3] <= hash_reg[3] + d_reg;
                    hash_reg[4] <= hash_reg[4] + e_reg; hash_reg[5] <= hash_reg[5] + f_reg;
                    hash_reg[6] <= hash_reg[6] + g_reg; hash_reg[7] <= hash_reg[7] + h_reg;
                    round_reg   <= '0;
                    out_idx_reg <= '0;
                    state_reg   <= final_reg ? ST_OUT : ST_LOAD;
                end
                ST_OUT:
                begin
                    if (pop)
                    begin
                        out_idx_reg <= out_idx_reg + 3'd1;
                        if (out_idx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                hash_reg[i] <= init_hash(3'(i));
                            end
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for sha512_hash_unit: random and directed messages,
// digests predicted in the testbench and compared word by word.
// Depends on sha512_pkg and the hash unit RTL.

class digest_scoreboard;
    logic [63:0] chain[8];
    logic [63:0] block[16];
    int          fill;
    logic [63:0] byte_count;
    logic [63:0] pending_word[$];
    logic [2:0]  pending_index[$];
    logic        pending_last[$];
    int          mismatches;

    function void restart();
        chain[0] = 64'h6a09e667f3bcc908; chain[1] = 64'hbb67ae8584caa73b;
        chain[2] = 64'h3c6ef372fe94f82b; chain[3] = 64'ha54ff53a5f1d36f1;
        chain[4] = 64'h510e527fade682d1; chain[5] = 64'h9b05688c2b3e6c1f;
        chain[6] = 64'h1f83d9abfb41bd6b; chain[7] = 64'h5be0cd19137e2179;
        fill = 0;
        byte_count = '0;
    endfunction

    function logic [63:0] ror(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function logic [63:0] kconst(int r);
        logic [63:0] k[80];
        k = '{
            64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
            64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
            64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
            64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
            64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
            64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
            64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
            64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
            64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
            64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
            64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
            64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
            64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
            64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
            64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
            64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
            64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
            64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
            64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
            64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
            64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
            64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
            64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
            64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
            64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
            64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
            64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
        return k[r];
    endfunction

    function void compress_block();
        logic [63:0] w[16];
        logic [63:0] v[8];
        logic [63:0] wr, t1, t2, x15, x2;
        w = block;
        v = chain;
        for (int r = 0; r < 80; r++)
        begin
            if (r < 16)
                wr = w[r];
            else
            begin
                x15 = w[(r + 1) % 16];
                x2 = w[(r + 14) % 16];
                wr = w[r % 16] + (ror(x15, 1) ^ ror(x15, 8) ^ (x15 >> 7)) + w[(r + 9) % 16]
                    + (ror(x2, 19) ^ ror(x2, 61) ^ (x2 >> 6));
                w[r % 16] = wr;
            end
            t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kconst(r) + wr;
            t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[i] += v[i];
    endfunction

    function void append(logic [63:0] w);
        block[fill] = w;
        fill = (fill + 1) % 16;
        if (fill == 0)
            compress_block();
    endfunction

    function void note_word(logic [63:0] data, logic [3:0] nbytes, logic final_word);
        int          n;
        logic [63:0] keep;
        if (!final_word)
        begin
            byte_count += 8;
            append(data);
            return;
        end
        n = (nbytes > 8) ? 8 : nbytes;
        byte_count += n;
        if (n == 8)
        begin
            append(data);
            append(64'h80 << 56);
        end
        else
        begin
            keep = (n == 0) ? '0 : ~64'h0 << (64 - 8 * n);
            append((data & keep) | (64'h80 << (56 - 8 * n)));
        end
        while (fill != 14)
            append('0);
        append('0);
        append(byte_count << 3);
        for (int k = 0; k < 8; k++)
        begin
            pending_word = {pending_word, chain[k]};
            pending_index = {pending_index, k[2:0]};
            pending_last = {pending_last, 1'(k == 7)};
        end
        restart();
    endfunction

    function void check_digest(logic [63:0] dw, logic [2:0] idx, logic lw);
        logic [63:0] ew;
        logic [2:0]  ei;
        logic        el;
        if (pending_word.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected digest transfer %h idx %0d", dw, idx);
            return;
        end
        ew = pending_word.pop_front();
        ei = pending_index.pop_front();
        el = pending_last.pop_front();
        if (dw !== ew || idx !== ei || lw !== el)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("digest mismatch: expected %h/%0d/%0b actual %h/%0d/%0b",
                         ew, ei, el, dw, idx, lw);
        end
    endfunction
endclass

module tb_top;
    import sha512_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        push = 0;
    logic        full;
    logic [63:0] message_word = '0;
    logic [3:0]  valid_bytes = '0;
    logic        is_last = 0;
    logic        empty;
    logic        pop = 0;
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    digest_scoreboard board;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_count = 0;
    int words_sent = 0;

    sha512_hash_unit uut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && push && !full)
            board.note_word(message_word, valid_bytes, is_last);
        if (rst_n && pop && !empty)
            board.check_digest(digest_word, word_index, last_word);
        if ((push && !full) || (pop && !empty))
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= 20000)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    always @(negedge clk)
        pop <= rst_n && ($urandom_range(99) >= recv_stall_pct);

    task automatic send_word(logic [63:0] data, logic [3:0] nbytes, logic final_word);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 0;
            @(negedge clk);
        end
        push <= 1;
        message_word <= data;
        valid_bytes <= nbytes;
        is_last <= final_word;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
        push <= 0;
        words_sent++;
    endtask

    task automatic send_message(int nwords, logic [3:0] nbytes);
        for (int i = 0; i < nwords - 1; i++)
            send_word({$urandom, $urandom}, 4'($urandom_range(15)), 1'b0);
        send_word({$urandom, $urandom}, nbytes, 1'b1);
    endtask

    task automatic drain();
        while (board.pending_word.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    initial
    begin
        board = new();
        board.restart();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send_word(64'h0, 4'd0, 1);
        send_word(64'hffffffffffffffff, 4'd8, 1);
        send_word(64'hffffffffffffffff, 4'd15, 1);
        send_word(64'h6162630000000000, 4'd3, 1);
        send_word(64'hffffffffffffffff, 4'd7, 1);
        send_word(64'hffffffffffffffff, 4'd1, 1);
        send_word(64'h0123456789abcdef, 4'd9, 1);
        send_word(64'h0, 4'd4, 0);
        send_word(64'hffffffffffffffff, 4'd5, 1);
        send_message(14, 4'd8);
        send_message(15, 4'd0);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 66 : 6) : 0;
            recv_stall_pct = (ph == 2) ? 66 : ((ph == 3) ? 6 : 0);
            while (words_sent < 95 * (ph + 1))
                send_message($urandom_range(4) == 0 ? $urandom_range(17, 40)
                             : $urandom_range(1, 16), 4'($urandom_range(15)));
            if (ph == 1)
                drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        if (board.mismatches == 0 && board.pending_word.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
